[rtl/range_kth_smallest_select_macros.svh]
// Assertion macros shared by the range k-th smallest select RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RANGE_KTH_SMALLEST_SELECT_MACROS_SVH
`define RANGE_KTH_SMALLEST_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RKSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in range_kth_smallest_select");

// The consequent must hold in the cycle after the antecedent.
`define RKSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in range_kth_smallest_select");

`endif

[rtl/rkss_pkg.sv]
// Package for the range k-th smallest select block: item types and constants.
// No dependencies.
package rkss_pkg;

    localparam int DEF_ARRAY_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int POS_W = 7;
    localparam int VAL_W = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    opcode;
        logic [POS_W-1:0]        index;
        logic signed [VAL_W-1:0] new_value;
        logic [POS_W-1:0]        range_left;
        logic [POS_W-1:0]        range_right;
        logic [POS_W-1:0]        rank;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] selected_value;
        logic                    error;
    } result_t;

endpackage

[rtl/rkss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rkss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/range_kth_smallest_select.sv]
// Range k-th smallest select; uses rkss_pkg, rkss_ram and the assertion macro header.
// A write item gives no result and does not raise busy. A query with bad bounds or rank
// shows its result in the cycle after acceptance. A valid query keeps busy high while
// it sweeps the element RAM once per value bit, each sweep followed by a drain state;
// the result shows as busy falls. Reset clears the sequencer and the result strobe, not
// the RAM; the receiver cannot stall.
module range_kth_smallest_select #(
    parameter int ARRAY_DEPTH = rkss_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_WIDTH = rkss_pkg::DEF_VALUE_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rkss_pkg::cmd_t    cmd,
    output logic              result_valid,
    output rkss_pkg::result_t result
);
    import rkss_pkg::*;

    `include "range_kth_smallest_select_macros.svh"

    localparam int AW  = $clog2(ARRAY_DEPTH);
    localparam int CW  = $clog2(ARRAY_DEPTH + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int BW  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int VW  = VALUE_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [PW-1:0] DEPTH_P = PW'(ARRAY_DEPTH);
    localparam logic [VW-1:0] SIGN_BIT = {1'b1, {(VW-1){1'b0}}};

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] left_reg, left_next;
    logic [AW-1:0] right_reg, right_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [VW-1:0] prefix_reg, prefix_next;
    logic          pend_reg, pend_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg, res_next;

    logic [PW-1:0] l_p, r_p, k_p, idx_p, len_p;
    logic          bad_query, accept, write_en;
    logic [AW-1:0] write_addr;
    logic [VW+VAL_W-1:0] new_ext;
    logic [VW-1:0] rdata, rkey, trial;
    logic          less;
    logic [CW-1:0] count_sum;
    logic [VW-1:0] last_key;
    logic [VAL_W+VW-1:0] out_ext;

    assign accept = start && !busy;

    assign l_p   = PW'(cmd.range_left);
    assign r_p   = PW'(cmd.range_right);
    assign k_p   = PW'(cmd.rank);
    assign idx_p = PW'(cmd.index);
    assign len_p = r_p - l_p + PW'(1);

    assign bad_query = (l_p == '0) || (r_p > DEPTH_P) || (l_p > r_p)
                       || (k_p == '0) || (k_p > len_p);

    // Writes land in the RAM on the accepting edge; out-of-range indexes are dropped.
    assign write_en   = accept && (cmd.opcode == OP_WRITE) && (idx_p != '0)
                        && (idx_p <= DEPTH_P);
    assign write_addr = AW'(idx_p - PW'(1));
    assign new_ext    = {{VW{cmd.new_value[VAL_W-1]}}, cmd.new_value};

    rkss_ram #(
        .WIDTH (VW),
        .DEPTH (ARRAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (write_en),
        .waddr (write_addr),
        .wdata (new_ext[VW-1:0]),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // Flipping the sign bit gives an unsigned key with the same order as the value.
    assign rkey      = rdata ^ SIGN_BIT;
    assign trial     = prefix_reg | (VW'(1) << bit_reg);
    assign less      = rkey < trial;
    assign count_sum = count_reg + CW'(pend_reg && less);
    assign last_key  = (count_sum < k_reg) ? trial : prefix_reg;
    assign out_ext   = {{VAL_W{1'b0}}, last_key ^ SIGN_BIT};

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        bit_next       = bit_reg;
        prefix_next    = prefix_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.opcode == OP_QUERY))
                begin
                    if (bad_query)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.selected_value = '0;
                        res_next.error          = 1'b1;
                    end
                    else
                    begin
                        left_next   = AW'(l_p - PW'(1));
                        right_next  = AW'(r_p - PW'(1));
                        addr_next   = AW'(l_p - PW'(1));
                        k_next      = CW'(k_p);
                        count_next  = '0;
                        bit_next    = BW'(VW - 1);
                        prefix_next = '0;
                        pend_next   = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                count_next = count_sum;
                pend_next  = 1'b1;
                if (addr_reg == right_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                // Fewer than k keys below the trial value: the answer is at or above it.
                if (count_sum < k_reg)
                begin
                    prefix_next = trial;
                end
                count_next = '0;
                pend_next  = 1'b0;
                addr_next  = left_reg;
                if (bit_reg == '0)
                begin
                    res_valid_next          = 1'b1;
                    res_next.selected_value = out_ext[VAL_W-1:0];
                    res_next.error          = 1'b0;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    bit_next   = bit_reg - BW'(1);
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        k_reg      <= k_next;
        count_reg  <= count_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        res_reg    <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `RKSS_ASSERT_SAME(a_error_gives_zero, result_valid && result.error, result.selected_value == '0)
    `RKSS_ASSERT_SAME(a_scan_in_range, state_reg == ST_SCAN, addr_reg <= right_reg)
    `RKSS_ASSERT_NEXT(a_query_goes_busy, accept && (cmd.opcode == OP_QUERY) && !bad_query, busy)
    `RKSS_ASSERT_SAME(a_count_bounded, state_reg != ST_IDLE, count_reg <= CW'(ARRAY_DEPTH))

endmodule

[verif/range_kth_smallest_select_tb.sv]
// Self-checking testbench for range_kth_smallest_select: writes and range k-th smallest queries.
// Needs the package rkss_pkg and the top module range_kth_smallest_select.
// A shadow copy of the element array predicts each query's answer.
`timescale 1ns / 1ps

module range_kth_smallest_select_tb;

    import rkss_pkg::*;

    localparam int DEPTH = DEF_ARRAY_DEPTH;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    result_valid;
    result_t result;

    int      shadow_elements [1:DEPTH];
    result_t pending_answers [$];
    int      fail_count;
    int      n_checked;
    int      n_writes;
    int      n_queries;
    int      n_rejected;

    range_kth_smallest_select i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The k-th smallest of the shadow range, found by an insertion sort of its values.
    function automatic result_t kth_smallest(cmd_t c);
        int      sorted_vals [DEPTH];
        int      n;
        int      lo;
        int      hi;
        int      k;
        int      v;
        int      j;
        result_t r;
        lo = int'(c.range_left);
        hi = int'(c.range_right);
        k = int'(c.rank);
        r.selected_value = '0;
        r.error = 1'b1;
        if (lo < 1 || hi > DEPTH || lo > hi)
            return r;
        if (k < 1 || k > hi - lo + 1)
            return r;
        n = 0;
        for (int i = lo; i <= hi; i++)
        begin
            v = shadow_elements[i];
            j = n;
            while (j > 0 && sorted_vals[j-1] > v)
            begin
                sorted_vals[j] = sorted_vals[j-1];
                j--;
            end
            sorted_vals[j] = v;
            n++;
        end
        r.selected_value = sorted_vals[k-1];
        r.error = 1'b0;
        return r;
    endfunction

    // Presents one item and holds it until the block takes it, then updates the shadow state.
    task automatic send_item(cmd_t c);
        result_t answer;
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        if (c.opcode == OP_WRITE)
        begin
            if (c.index >= 1 && c.index <= DEPTH)
            begin
                shadow_elements[c.index] = c.new_value;
                n_writes++;
            end
        end
        else
        begin
            answer = kth_smallest(c);
            pending_answers.push_back(answer);
            n_queries++;
            if (answer.error)
                n_rejected++;
        end
    endtask

    // Drops start for a random number of cycles, each cycle idle with the given chance.
    task automatic idle_gap(int pct);
        while ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    function automatic cmd_t write_cmd(int pos, int value);
        cmd_t c;
        c.opcode = OP_WRITE;
        c.index = POS_W'(pos);
        c.new_value = value;
        c.range_left = POS_W'($urandom);
        c.range_right = POS_W'($urandom);
        c.rank = POS_W'($urandom);
        return c;
    endfunction

    function automatic cmd_t query_cmd(int lo, int hi, int k);
        cmd_t c;
        c.opcode = OP_QUERY;
        c.index = POS_W'($urandom);
        c.new_value = $urandom;
        c.range_left = POS_W'(lo);
        c.range_right = POS_W'(hi);
        c.rank = POS_W'(k);
        return c;
    endfunction

    // Small values give plenty of duplicates; the extremes test signed ordering.
    function automatic int pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return int'($urandom_range(8)) - 4;
        if (r < 35)
            return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return $urandom;
    endfunction

    // Mostly short ranges keep the run short; a few span from 25 elements up to the whole array.
    function automatic cmd_t random_query();
        int len;
        int lo;
        int k;
        int r;
        r = $urandom_range(99);
        if (r < 90)
            len = $urandom_range(8, 1);
        else if (r < 98)
            len = $urandom_range(24, 9);
        else
            len = $urandom_range(DEPTH, 25);
        lo = $urandom_range(DEPTH - len + 1, 1);
        if ($urandom_range(99) < 5)
            k = $urandom_range(1) ? 0 : len + 1;
        else
            k = $urandom_range(len, 1);
        return query_cmd(lo, lo + len - 1, k);
    endfunction

    // Bounds errors read no element, so they may come before the array is loaded.
    task automatic test_bad_bounds();
        send_item(query_cmd(0, 5, 1));
        send_item(query_cmd(3, DEPTH + 1, 1));
        send_item(query_cmd(10, 9, 1));
        send_item(query_cmd(127, 127, 127));
        send_item(query_cmd(1, 127, 1));
        send_item(query_cmd(DEPTH, 1, 1));
    endtask

    task automatic test_load_store();
        send_item(write_cmd(1, 32'h8000_0000));
        send_item(write_cmd(2, 32'h7fff_ffff));
        send_item(write_cmd(3, 0));
        send_item(write_cmd(4, -1));
        for (int p = 5; p <= DEPTH; p++)
            send_item(write_cmd(p, pick_value()));
    endtask

    task automatic test_ignored_writes();
        send_item(write_cmd(0, 32'h5555_5555));
        send_item(write_cmd(DEPTH + 1, 32'haaaa_aaaa));
        send_item(write_cmd(127, 32'h7fff_fffe));
        send_item(query_cmd(1, DEPTH, 1));
        send_item(query_cmd(1, DEPTH, DEPTH));
    endtask

    task automatic test_rank_limits();
        send_item(query_cmd(1, DEPTH, 0));
        send_item(query_cmd(1, DEPTH, DEPTH + 1));
        send_item(query_cmd(1, DEPTH, 127));
        send_item(query_cmd(1, DEPTH, DEPTH / 2));
        send_item(query_cmd(DEPTH, DEPTH, 1));
        send_item(query_cmd(DEPTH, DEPTH, 2));
        send_item(query_cmd(1, 1, 1));
        send_item(query_cmd(1, 4, 3));
    endtask

    // Most items are stored writes and well-formed queries; the rest is noise.
    task automatic test_random_traffic(int items, int sender_idle_pct);
        int   sent;
        int   r;
        cmd_t c;
        sent = 0;
        while (sent < items)
        begin
            idle_gap(sender_idle_pct);
            r = $urandom_range(99);
            if (r < 40)
            begin
                c = write_cmd($urandom_range(DEPTH, 1), pick_value());
                sent++;
            end
            else if (r < 43)
            begin
                c = write_cmd($urandom_range(1) ? 0 : $urandom_range(127, DEPTH + 1),
                              pick_value());
            end
            else if (r < 90)
            begin
                c = random_query();
                sent++;
            end
            else
            begin
                c = query_cmd($urandom_range(127), $urandom_range(127), $urandom_range(127));
                sent++;
            end
            send_item(c);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d error %0b",
                         $time, result.selected_value, result.error);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                n_checked++;
                if (result.error !== want.error)
                begin
                    $display("%0t: error flag mismatch, expected %0b, got %0b",
                             $time, want.error, result.error);
                    fail_count++;
                end
                if (result.selected_value !== want.selected_value)
                begin
                    $display("%0t: selected value mismatch, expected %0d, got %0d",
                             $time, want.selected_value, result.selected_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #(200_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
        $display("range_kth_smallest_select regression: fail");
        $finish;
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        fail_count = 0;
        n_checked = 0;
        n_writes = 0;
        n_queries = 0;
        n_rejected = 0;
        for (int p = 1; p <= DEPTH; p++)
            shadow_elements[p] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_bounds();
        test_load_store();
        test_ignored_writes();
        test_rank_limits();
        test_random_traffic(570, 8);
        test_random_traffic(570, 73);
        test_random_traffic(570, 0);

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (pending_answers.size() != 0 && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
            fail_count++;
        end

        $display("Stored %0d element writes and issued %0d queries, %0d of them rejected.",
                 n_writes, n_queries, n_rejected);
        $display("Checked %0d results; %0d mismatches found.", n_checked, fail_count);
        if (fail_count == 0)
            $display("range_kth_smallest_select regression: pass");
        else
            $display("range_kth_smallest_select regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/rkss_pkg.sv
rtl/rkss_ram.sv
rtl/range_kth_smallest_select.sv
verif/range_kth_smallest_select_tb.sv
